@@ design/fspb_pkg.sv @@
package fspb_pkg;

  localparam logic [1:0] FMT_PCM16 = 2'd0;
  localparam logic [1:0] FMT_PCM24 = 2'd1;
  localparam logic [1:0] FMT_FLOAT = 2'd2;

  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [1:0] REG_BIG_ENDIAN    = 2'd1;
  localparam logic [1:0] REG_GAIN_BITS     = 2'd2;

  localparam logic [31:0] GAIN_RESET = 32'h3F80_0000;
  localparam logic [31:0] CANON_QNAN = 32'h7FC0_0000;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        last_channel;
    logic        last_frame;
  } fspb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_sample;
    logic       end_of_frame;
    logic       end_of_block;
  } fspb_out_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  fmt;
    logic        big_endian;
    logic        last_channel;
    logic        last_frame;
  } fspb_job_t;

endpackage

@@ design/fspb_front.sv @@
module fspb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fspb_pkg::fspb_in_t  in_data_i,
  input  logic [1:0]          fmt_i,
  input  logic                big_endian_i,
  input  logic [31:0]         gain_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output fspb_pkg::fspb_job_t job_o
);

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || job_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  logic take;
  assign take = in_valid_i && (fmt_i != 2'd3);

  // stage 1: classify and multiply mantissas
  logic [7:0]  ea, eb, eae, ebe;
  logic [22:0] fa, fb;
  logic [4:0]  scale;
  logic        a_zero, a_inf, a_nan, b_zero, b_inf, b_nan, k_inf;
  logic signed [10:0] exp1;

  always_comb begin
    ea = in_data_i.sample_bits[30:23];
    fa = in_data_i.sample_bits[22:0];
    eb = gain_i[30:23];
    fb = gain_i[22:0];
    unique case (fmt_i)
      fspb_pkg::FMT_PCM16: scale = 5'd15;
      fspb_pkg::FMT_PCM24: scale = 5'd23;
      default:             scale = 5'd0;
    endcase
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    k_inf  = (eb != 8'hFF) && (({1'b0, eb} + {4'b0, scale}) >= 9'd255);
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    exp1 = 11'({3'b0, eae}) + 11'({3'b0, ebe}) + 11'({6'b0, scale}) - 11'sd126;
  end

  logic [47:0]        prod1_q;
  logic signed [10:0] exp1_q;
  logic               sign1_q, nan1_q, inf1_q;
  logic [1:0]         fmt1_q, fmt2_q, fmt3_q, fmt4_q;
  logic               be1_q, be2_q, be3_q, be4_q;
  logic               lc1_q, lc2_q, lc3_q, lc4_q;
  logic               lf1_q, lf2_q, lf3_q, lf4_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && take) begin
      prod1_q <= {1'b0, 24'({ea != 8'd0, fa})} * {1'b0, 24'({eb != 8'd0, fb})};
      exp1_q  <= exp1;
      sign1_q <= in_data_i.sample_bits[31] ^ gain_i[31];
      nan1_q  <= a_nan || b_nan || ((a_inf || b_inf || k_inf) && (a_zero || b_zero));
      inf1_q  <= a_inf || b_inf || k_inf;
      fmt1_q  <= fmt_i;
      be1_q   <= big_endian_i;
      lc1_q   <= in_data_i.last_channel;
      lf1_q   <= in_data_i.last_frame;
    end
  end

  // stage 2: normalize left
  logic [5:0]         lz;
  logic [47:0]        pn_q;
  logic signed [10:0] exp2_q;
  logic               sign2_q, nan2_q, inf2_q, zero2_q;

  assign lz = lzc48(prod1_q);

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      pn_q    <= prod1_q << lz;
      exp2_q  <= exp1_q - $signed({5'b0, lz});
      sign2_q <= sign1_q;
      nan2_q  <= nan1_q;
      inf2_q  <= inf1_q;
      zero2_q <= (prod1_q == 48'd0);
      fmt2_q  <= fmt1_q;
      be2_q   <= be1_q;
      lc2_q   <= lc1_q;
      lf2_q   <= lf1_q;
    end
  end

  // stage 3: denormalize and round to nearest even
  logic signed [10:0] sh_full;
  logic [5:0]         sh;
  logic [47:0]        q, lost_mask;
  logic [30:0]        base;
  logic               guard, sticky, lsb, rnd;
  logic [31:0]        x3;

  always_comb begin
    sh_full   = 11'sd1 - exp2_q;
    sh        = (sh_full > 11'sd26) ? 6'd26 : sh_full[5:0];
    q         = pn_q >> sh;
    lost_mask = ~(48'hFFFF_FFFF_FFFF << sh);
    if (exp2_q >= 11'sd1) begin
      base   = {exp2_q[7:0], pn_q[46:24]};
      guard  = pn_q[23];
      sticky = |pn_q[22:0];
      lsb    = pn_q[24];
    end else begin
      base   = {8'd0, q[46:24]};
      guard  = q[23];
      sticky = (|q[22:0]) || (|(pn_q & lost_mask));
      lsb    = q[24];
    end
    rnd = guard && (sticky || lsb);
    priority if (nan2_q) begin
      x3 = fspb_pkg::CANON_QNAN;
    end else if (inf2_q || (!zero2_q && exp2_q > 11'sd254)) begin
      x3 = {sign2_q, 8'hFF, 23'd0};
    end else if (zero2_q) begin
      x3 = {sign2_q, 31'd0};
    end else begin
      x3 = {sign2_q, base + {30'd0, rnd}};
    end
  end

  logic [31:0] x3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      x3_q   <= x3;
      fmt3_q <= fmt2_q;
      be3_q  <= be2_q;
      lc3_q  <= lc2_q;
      lf3_q  <= lf2_q;
    end
  end

  // stage 4: floor and saturate for the PCM formats
  logic [7:0]         xe;
  logic [22:0]        xf;
  logic [23:0]        xm, ip, fmask;
  logic [4:0]         xsh;
  logic               xneg, xnan, fnz;
  logic [7:0]         big_thr, tiny_thr;
  logic signed [24:0] maxv, mag, v;
  logic [31:0]        word4;

  always_comb begin
    xe   = x3_q[30:23];
    xf   = x3_q[22:0];
    xm   = {1'b1, xf};
    xneg = x3_q[31];
    xnan = (xe == 8'hFF) && (xf != 23'd0);
    if (fmt3_q == fspb_pkg::FMT_PCM16) begin
      big_thr  = 8'd142;
      tiny_thr = 8'd88;
      maxv     = 25'sd32767;
    end else begin
      big_thr  = 8'd150;
      tiny_thr = 8'd96;
      maxv     = 25'sd8388607;
    end
    xsh   = 5'(8'd150 - xe);
    ip    = xm >> xsh;
    fmask = ~(24'hFF_FFFF << xsh);
    fnz   = |(xm & fmask);
    mag   = $signed({1'b0, ip}) + $signed({24'd0, fnz});
    priority if (xnan) begin
      v = 25'sd0;
    end else if (xe >= big_thr) begin
      v = xneg ? -maxv : maxv;
    end else if (xe < 8'd127) begin
      if (!xneg || (xe == 8'd0 && xf == 23'd0) || xe < tiny_thr ||
          (xe == tiny_thr && xf == 23'd0)) begin
        v = 25'sd0;
      end else begin
        v = -25'sd1;
      end
    end else if (xneg) begin
      v = (-mag < -maxv) ? -maxv : -mag;
    end else begin
      v = $signed({1'b0, ip});
    end
    word4 = (fmt3_q == fspb_pkg::FMT_FLOAT) ? x3_q : 32'(v);
  end

  logic [31:0] word4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      word4_q <= word4;
      fmt4_q  <= fmt3_q;
      be4_q   <= be3_q;
      lc4_q   <= lc3_q;
      lf4_q   <= lf3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= take;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign job_valid_o        = v4_q;
  assign job_o.word         = word4_q;
  assign job_o.fmt          = fmt4_q;
  assign job_o.big_endian   = be4_q;
  assign job_o.last_channel = lc4_q;
  assign job_o.last_frame   = lf4_q;

endmodule

@@ design/fspb_fifo.sv @@
module fspb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                ready_o,
  input  fspb_pkg::fspb_job_t data_i,
  output logic                valid_o,
  input  logic                pop_i,
  output fspb_pkg::fspb_job_t data_o
);

  fspb_pkg::fspb_job_t mem_q [fspb_pkg::QDEPTH];
  logic [fspb_pkg::QAW-1:0] wr_q, rd_q;
  logic [fspb_pkg::QAW:0]   cnt_q;
  logic                     do_push, do_pop;

  assign ready_o = (cnt_q != (fspb_pkg::QAW+1)'(fspb_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (fspb_pkg::QAW+1)'(do_push) - (fspb_pkg::QAW+1)'(do_pop);
    end
  end

endmodule

@@ design/fspb_back.sv @@
module fspb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  fspb_pkg::fspb_job_t   head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output fspb_pkg::fspb_out_t   out_data_o
);

  logic [1:0]          cnt_q, nb_m1, pos;
  logic                ov_q, load, last;
  fspb_pkg::fspb_out_t out_q;
  logic [7:0]          sel;

  always_comb begin
    unique case (head_i.fmt)
      fspb_pkg::FMT_PCM16: nb_m1 = 2'd1;
      fspb_pkg::FMT_PCM24: nb_m1 = 2'd2;
      default:             nb_m1 = 2'd3;
    endcase
    pos  = head_i.big_endian ? (nb_m1 - cnt_q) : cnt_q;
    sel  = head_i.word[8*pos +: 8];
    last = (cnt_q == nb_m1);
    load = head_valid_i && (!ov_q || out_ready_i);
  end

  assign pop_o       = load && last;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte       <= sel;
      out_q.last_of_sample <= last;
      out_q.end_of_frame   <= last && head_i.last_channel;
      out_q.end_of_block   <= last && head_i.last_channel && head_i.last_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        cnt_q <= last ? 2'd0 : cnt_q + 2'd1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  a_mid_sample_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd0 |-> head_valid_i)
    else $error("head dropped mid-sample");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> cnt_q <= nb_m1)
    else $error("byte counter past sample length");

  a_flag_nesting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_q.end_of_block |-> out_q.end_of_frame && out_q.last_of_sample)
    else $error("end flags out of order");

endmodule

@@ design/float_sample_to_pcm_bytes.sv @@
// Float sample to PCM byte stream.
// Input channel (in_valid_i/in_ready_o/in_data_i): one single-precision sample per
// beat with its last_channel and last_frame marks.
// Output channel (out_valid_o/out_ready_i/out_data_o): one byte per beat, two, three
// or four beats per sample for 16-bit, 24-bit and float formats, with the final
// byte of each sample carrying the sample, frame and block marks.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always ready;
// index 0 sample format, 1 byte order, 2 gain. Write only while the block is idle.
// The first byte of a sample passes through the four arithmetic stages and the job
// queue, then the output register. Throughput: one byte per cycle on the output
// while the receiver is ready, set by the byte serializer; the arithmetic pipeline
// takes a sample every cycle unless back-pressure from the queue holds it.
// Samples written with the reserved format are taken and dropped.
// Reset clears all pipeline and queue valid state and loads format 16-bit PCM,
// little-endian and unity gain.
// A stalled receiver holds the current byte; the two-entry queue and the four
// arithmetic stages then fill up and in_ready_o drops.
module float_sample_to_pcm_bytes (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fspb_pkg::fspb_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fspb_pkg::fspb_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic [1:0]  fmt_q;
  logic        be_q;
  logic [31:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= fspb_pkg::FMT_PCM16;
      be_q   <= 1'b0;
      gain_q <= fspb_pkg::GAIN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fspb_pkg::REG_SAMPLE_FORMAT: fmt_q  <= cfg_data_i[1:0];
        fspb_pkg::REG_BIG_ENDIAN:    be_q   <= cfg_data_i[0];
        fspb_pkg::REG_GAIN_BITS:     gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                job_valid, job_ready, head_valid, pop;
  fspb_pkg::fspb_job_t job, head;

  fspb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .fmt_i        (fmt_q),
    .big_endian_i (be_q),
    .gain_i       (gain_q),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job)
  );

  fspb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .ready_o (job_ready),
    .data_i  (job),
    .valid_o (head_valid),
    .pop_i   (pop),
    .data_o  (head)
  );

  fspb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ dv/fspb_checker.sv @@
module fspb_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  fspb_pkg::fspb_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  fspb_pkg::fspb_out_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  bytes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [1:0]          fmt_q;
  logic                big_endian_q;
  logic [31:0]         gain_q;
  fspb_pkg::fspb_out_t byte_fifo[$];
  int                  n_err;
  int                  n_bytes;

  function automatic logic is_nan(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  endfunction

  // exact magnitude of a finite single as a double
  function automatic real single_mag(logic [31:0] b);
    real scale;
    scale = $bitstoreal({1'b0, 11'(1023 - 149), 52'd0});
    if (b[30:23] == 8'd0) return real'(b[22:0]) * scale;
    return $bitstoreal({1'b0, 11'({3'd0, b[30:23]} + 11'd896), b[22:0], 29'd0});
  endfunction

  // round a positive finite double to single, nearest even, with subnormals
  function automatic logic [31:0] round_single(logic sgn, real mag);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    int          e;
    int          sh;
    d = $realtobits(mag);
    e = int'(d[62:52]) - 1023;
    m = {11'd0, 1'b1, d[51:0]};
    sh = (e < -126) ? 29 + (-126 - e) : 29;
    if (sh > 60) sh = 60;
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (e < -126) return {sgn, q[30:0]};
    if (q[24]) begin
      q = q >> 1;
      e++;
    end
    if (e > 127) return {sgn, 8'hFF, 23'd0};
    return {sgn, 8'(e + 127), q[22:0]};
  endfunction

  function automatic logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return fspb_pkg::CANON_QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return fspb_pkg::CANON_QNAN;
      return {sgn, 8'hFF, 23'd0};
    end
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
    return round_single(sgn, single_mag(a) * single_mag(b));
  endfunction

  function automatic logic [31:0] pcm_word(logic [31:0] x, logic wide);
    real offset;
    real xr;
    real s;
    int  maxv;
    int  v;
    offset = wide ? 8388608.0 : 32768.0;
    maxv = wide ? 8388607 : 32767;
    if (is_nan(x)) return 32'd0;
    if (is_inf(x)) xr = $bitstoreal({x[31], 11'h7FF, 52'd0});
    else xr = x[31] ? -single_mag(x) : single_mag(x);
    s = offset + xr;
    if (s < 1.0) v = -maxv;
    else if (s >= 2.0 * offset) v = maxv;
    else begin
      v = $rtoi(s) - $rtoi(offset);
      if (v > maxv) v = maxv;
      if (v < -maxv) v = -maxv;
    end
    return 32'(v);
  endfunction

  task automatic queue_sample_bytes(fspb_pkg::fspb_in_t smp);
    logic [31:0]         word;
    fspb_pkg::fspb_out_t b;
    int                  nbytes;
    int                  pos;
    case (fmt_q)
      fspb_pkg::FMT_PCM16: begin
        word = pcm_word(single_mul(smp.sample_bits, single_mul(gain_q, 32'h4700_0000)), 1'b0);
        nbytes = 2;
      end
      fspb_pkg::FMT_PCM24: begin
        word = pcm_word(single_mul(smp.sample_bits, single_mul(gain_q, 32'h4B00_0000)), 1'b1);
        nbytes = 3;
      end
      fspb_pkg::FMT_FLOAT: begin
        word = single_mul(smp.sample_bits, gain_q);
        nbytes = 4;
      end
      default: begin
        word = 32'd0;
        nbytes = 0;
      end
    endcase
    for (int i = 0; i < nbytes; i++) begin
      pos = big_endian_q ? nbytes - 1 - i : i;
      b.out_byte = word[8*pos +: 8];
      b.last_of_sample = (i == nbytes - 1);
      b.end_of_frame = b.last_of_sample && smp.last_channel;
      b.end_of_block = b.end_of_frame && smp.last_frame;
      byte_fifo.push_back(b);
    end
  endtask

  task automatic compare_byte(fspb_pkg::fspb_out_t got);
    fspb_pkg::fspb_out_t exp_b;
    if (byte_fifo.size() == 0) begin
      $error("unexpected output byte %h", got.out_byte);
      n_err++;
      return;
    end
    exp_b = byte_fifo.pop_front();
    if (got.out_byte !== exp_b.out_byte) begin
      $error("out_byte: expected %h, got %h", exp_b.out_byte, got.out_byte);
      n_err++;
    end
    if (got.last_of_sample !== exp_b.last_of_sample) begin
      $error("last_of_sample: expected %b, got %b", exp_b.last_of_sample, got.last_of_sample);
      n_err++;
    end
    if (got.end_of_frame !== exp_b.end_of_frame) begin
      $error("end_of_frame: expected %b, got %b", exp_b.end_of_frame, got.end_of_frame);
      n_err++;
    end
    if (got.end_of_block !== exp_b.end_of_block) begin
      $error("end_of_block: expected %b, got %b", exp_b.end_of_block, got.end_of_block);
      n_err++;
    end
  endtask

  initial begin
    n_err = 0;
    n_bytes = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= fspb_pkg::FMT_PCM16;
      big_endian_q <= 1'b0;
      gain_q <= fspb_pkg::GAIN_RESET;
    end else begin
      if (out_valid_i && out_ready_i) begin
        compare_byte(out_data_i);
        n_bytes++;
      end
      if (in_valid_i && in_ready_i) queue_sample_bytes(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fspb_pkg::REG_SAMPLE_FORMAT: fmt_q <= cfg_data_i[1:0];
          fspb_pkg::REG_BIG_ENDIAN:    big_endian_q <= cfg_data_i[0];
          fspb_pkg::REG_GAIN_BITS:     gain_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
    errors_o <= n_err;
    pending_o <= byte_fifo.size();
    bytes_o <= n_bytes;
  end

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FMT_RESERVED = 2'd3;
  localparam int         IDLE_LIMIT   = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  fspb_pkg::fspb_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  fspb_pkg::fspb_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [31:0]         cfg_data = '0;
  int                  errors;
  int                  pending;
  int                  bytes_seen;

  int          stall_mode = 0;
  int          stall_phase = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          samples_sent = 0;
  int          settings_run = 0;
  int          chan_idx = 0;
  int          chan_count = 2;

  float_sample_to_pcm_bytes i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  fspb_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .bytes_o    (bytes_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((stall_phase % 11) < 3);
      default: out_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_sample(logic [31:0] bits, logic lc, logic lf);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data.sample_bits <= bits;
    in_data.last_channel <= lc;
    in_data.last_frame <= lf;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(logic [1:0] fmt, logic be, logic [31:0] gain);
    drain();
    write_reg(fspb_pkg::REG_SAMPLE_FORMAT, {30'd0, fmt});
    write_reg(fspb_pkg::REG_BIG_ENDIAN, {31'd0, be});
    write_reg(fspb_pkg::REG_GAIN_BITS, gain);
    cfg_valid <= 1'b0;
    stall_mode = $urandom_range(0, 3);
    chan_count = $urandom_range(1, 4);
    chan_idx = 0;
    settings_run++;
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                                  32'h3F80_0000, 32'hBF80_0000, 32'h7F7F_FFFF,
                                  32'h0000_0001};
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return {r[31], 8'($urandom_range(100, 127)), r[22:0]};
      6: return r;
      7: return {r[31], 8'($urandom_range(126, 128)), r[22:0]};
      8: return specials[$urandom_range(0, 9)];
      default: return {r[31], 8'($urandom_range(0, 3)), r[22:0]};
    endcase
  endfunction

  task automatic random_frames(int count);
    logic lc;
    for (int i = 0; i < count; i++) begin
      lc = (chan_idx == chan_count - 1);
      if ($urandom_range(0, 15) == 0) lc = ~lc;
      send_sample(pick_sample(), lc, lc && ($urandom_range(0, 4) == 0));
      chan_idx = lc ? 0 : chan_idx + 1;
    end
  endtask

  initial begin
    logic [31:0] directed[22] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
      32'h3F00_0000, 32'h3F7F_FFFF, 32'h3F80_0001, 32'hBF80_0001,
      32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
      32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001,
      32'hB000_0000, 32'h3000_0000, 32'h3800_0000, 32'hB800_0000,
      32'h3EAA_AAAB, 32'hBF40_0000};
    logic [1:0]  fmts[10] = '{fspb_pkg::FMT_PCM16, fspb_pkg::FMT_PCM24, fspb_pkg::FMT_FLOAT,
                              fspb_pkg::FMT_FLOAT, FMT_RESERVED, fspb_pkg::FMT_PCM16,
                              fspb_pkg::FMT_PCM24, fspb_pkg::FMT_FLOAT, fspb_pkg::FMT_PCM16,
                              fspb_pkg::FMT_PCM24};
    logic [31:0] gains[10] = '{32'h3F00_0000, 32'h3F80_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                              32'h3F80_0000, 32'h4000_0000, 32'h7F7F_FFFF, 32'h0000_0001,
                              32'h0, 32'h0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stall_mode = 1;
    foreach (directed[i])
      send_sample(directed[i], i[0], (i % 4) == 3);

    foreach (fmts[i]) begin
      apply_setting(fmts[i], i[0] ^ (i > 4), (i >= 8) ? $urandom : gains[i]);
      for (int p = 0; p < 6; p++)
        send_sample(directed[$urandom_range(0, 21)], p[0], p == 5);
      random_frames(fmts[i] == FMT_RESERVED ? 10 : 41);
    end

    drain();
    $display("%0d samples over %0d register settings, %0d bytes checked",
             samples_sent, settings_run, bytes_seen);
    $display("directed edge values plus random audio-range, special and raw samples");
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending != 0) $error("%0d expected bytes never arrived", pending);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fspb_pkg.sv
design/fspb_front.sv
design/fspb_fifo.sv
design/fspb_back.sv
design/float_sample_to_pcm_bytes.sv
dv/fspb_checker.sv
dv/testbench.sv
